@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CELL_W = $clog2(CELLS);
	localparam int DATA_W = 16;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CODE_LINEFEED  = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CODE_FIRST_HI  = 8'h80;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'hF4;

	typedef struct packed {
		logic              scrolled;
		logic [DATA_W-1:0] read_data;
		logic [CELL_W-1:0] cursor_location;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} tcw_result_t;

endpackage

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: cursor update, character writes, scroll copy, row and
// screen fills, and cell reads against the cell memory.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_type,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [CELL_W-1:0] cell_index,
	output logic              res_valid,
	input  logic              res_ready,
	output tcw_result_t       res,
	output logic              ram_we,
	output logic [CELL_W-1:0] ram_waddr,
	output logic [DATA_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [CELL_W-1:0] ram_raddr,
	input  logic [DATA_W-1:0] ram_rdata
);

	localparam int NCOL_W  = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int TAB_MAX = (COLUMNS - 1) / TAB_STOP + 1;

	localparam logic [CELL_W-1:0] COPY_LAST  = CELL_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [CELL_W-1:0] FILL_START = CELL_W'((ROWS - 1) * COLUMNS);
	localparam logic [CELL_W-1:0] CELL_LAST  = CELL_W'(CELLS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RDWAIT = 3'd1;
	localparam logic [2:0] ST_COPY   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [CELL_W-1:0] cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ATTR_W-1:0] attr_q;
	logic [DATA_W-1:0] rd_q;
	logic              scr_q;
	logic              inrange_q;
	logic [CELL_W-1:0] cp_addr_s1;
	logic              cp_valid_s1;

	logic              accept;
	logic              printable;
	logic [NCOL_W-1:0] ncol;
	logic [NCOL_W-1:0] tab_col;
	logic [ROW_W:0]    nrow;
	logic              need_scroll;
	logic [COL_W-1:0]  put_col;
	logic [ROW_W-1:0]  put_row;
	logic [CELL_W-1:0] cur_loc;
	logic              idx_ok;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign printable = (char_code >= CODE_SPACE) && (char_code < CODE_FIRST_HI);
	assign idx_ok    = (cell_index < CELL_W'(CELLS));
	assign cur_loc   = CELL_W'({{(CELL_W - ROW_W){1'b0}}, row_q} * CELL_W'(COLUMNS))
		+ CELL_W'(col_q);

	always_comb begin
		tab_col = NCOL_W'(TAB_MAX * TAB_STOP);
		for (int k = TAB_MAX; k >= 1; k--) begin
			if (NCOL_W'(col_q) < NCOL_W'(k * TAB_STOP)) begin
				tab_col = NCOL_W'(k * TAB_STOP);
			end
		end
	end

	always_comb begin
		ncol = NCOL_W'(col_q);
		nrow = (ROW_W + 1)'(row_q);
		unique case (char_code)
			CODE_BACKSPACE: begin
				if (col_q != '0) begin
					ncol = NCOL_W'(col_q) - NCOL_W'(1);
				end
			end
			CODE_TAB: begin
				ncol = tab_col;
			end
			CODE_RETURN: begin
				ncol = '0;
			end
			CODE_LINEFEED: begin
				ncol = '0;
				nrow = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(1);
			end
			default: begin
				if (printable) begin
					ncol = NCOL_W'(col_q) + NCOL_W'(1);
				end
			end
		endcase
		if (ncol >= NCOL_W'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + (ROW_W + 1)'(1);
		end
		need_scroll = (nrow >= (ROW_W + 1)'(ROWS));
		put_col     = ncol[COL_W-1:0];
		put_row     = need_scroll ? ROW_W'(ROWS - 1) : nrow[ROW_W-1:0];
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_loc;
		ram_wdata = {attr_q, char_code};
		ram_re    = 1'b0;
		ram_raddr = cell_index;
		if (cp_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == ST_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = {attr_q, CODE_SPACE};
		end else if (accept && req_type == REQ_PUT && printable) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_COPY) begin
			ram_re    = 1'b1;
			ram_raddr = cnt_q + CELL_W'(COLUMNS);
		end else if (accept && req_type == REQ_READ) begin
			ram_re = idx_ok;
		end
	end

	assign res_valid           = (state_q == ST_DONE);
	assign res.scrolled        = scr_q;
	assign res.read_data       = rd_q;
	assign res.cursor_location = cur_loc;
	assign res.cursor_row      = row_q;
	assign res.cursor_col      = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			cp_valid_s1 <= 1'b0;
		end else begin
			cp_valid_s1 <= (state_q == ST_COPY);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_PUT: begin
								col_q   <= put_col;
								row_q   <= put_row;
								cnt_q   <= '0;
								state_q <= need_scroll ? ST_COPY : ST_DONE;
							end
							REQ_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							REQ_READ: begin
								state_q <= ST_RDWAIT;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					if (cnt_q == COPY_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CELL_W'(1);
					end
				end
				ST_DRAIN: begin
					cnt_q   <= FILL_START;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (cnt_q == CELL_LAST) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CELL_W'(1);
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q;
		if (accept) begin
			scr_q     <= (req_type == REQ_PUT) && need_scroll;
			rd_q      <= '0;
			inrange_q <= idx_ok;
		end else if (state_q == ST_RDWAIT) begin
			rd_q <= inrange_q ? ram_rdata : '0;
		end
	end

endmodule

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console with a cell memory of attribute and character pairs,
// a cursor with control-code handling, line wrap, scroll and clear.
//
//   Channel  Signals                     Beat contents
//   input    s_tvalid/s_tready/s_t*      req_type, char_code, cell_index
//   output   m_tvalid/m_tready/m_tdata   cursor, location, read data, scroll
//   config   cfg_we/cfg_wdata            cell attribute byte
//
// A put or an unused request goes from idle straight to the result state, a
// read via a read-wait state. A scrolling put moves the lower rows up by one
// and blanks the last row, a clear blanks every cell, each with one write per
// cell through the single memory write port. Reset clears the cursor and sets
// the attribute register to ATTR_RESET, not the cell memory. A result waiting
// in the output register does not block the next beat from being taken.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // char_code, cell_index, zero fill
	input  logic [1:0]        s_tuser,   // req_type
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata    // cursor_col, cursor_row,
	                                     // cursor_location, read_data, scrolled
);

	tcw_result_t       res;
	tcw_result_t       res_q;
	logic              res_valid;
	logic              res_ready;
	logic              m_tvalid_q;
	logic              ram_we;
	logic [CELL_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [CELL_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	tcw_ram #(
		.DEPTH(CELLS),
		.WIDTH(DATA_W),
		.AW   (CELL_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_type  (s_tuser),
		.char_code (s_tdata[CHAR_W-1:0]),
		.cell_index(s_tdata[CHAR_W+CELL_W-1:CHAR_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console writer. A directed table covers
// clear, reads at and past the screen edges, every control code, ignored
// codes, attribute changes, scroll by line feed and wrap by tab. Random
// requests follow in three phases with different idle patterns on both
// stream sides. Every result beat is compared field by field against a typed
// table result or a shadow copy of the screen, cursor and attribute register.
// ----------------------------------------------------------------------------
module testbench;
	import tcw_pkg::*;

	localparam logic [1:0]  REQ_UNUSED       = 2'd3;
	localparam int          LAST_INDEX       = (1 << CELL_W) - 1;
	localparam int          RANDOM_PER_PHASE = 230;
	localparam int          HOLD_CYCLES      = 600;
	localparam int          SETTLE_CYCLES    = 4;
	localparam int          TAIL_CYCLES      = 2100;
	localparam int          WATCHDOG_LIMIT   = 20000;
	localparam int          SENDER_IDLE [3]  = '{23, 78, 0};
	localparam int          RECEIVER_IDLE [3] = '{78, 23, 0};

	typedef enum bit {ROW_REQUEST, ROW_ATTRIBUTE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        req;
		logic [CHAR_W-1:0] code;
		logic [CELL_W-1:0] idx;
		logic [5:0]        reps;
		bit                typed;
		tcw_result_t       result;
	} stim_row_t;

	// Typed results are {scrolled, read_data, cursor_location, cursor_row, cursor_col}.
	localparam stim_row_t DIRECTED_ROWS [29] = '{
		'{ROW_REQUEST, REQ_CLEAR, 8'h00, 11'd0, 6'd1, 1'b1,
			{1'b0, 16'h0000, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd0, 6'd1, 1'b1,
			{1'b0, 16'hF420, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd1999, 6'd1, 1'b1,
			{1'b0, 16'hF420, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd2047, 6'd1, 1'b1,
			{1'b0, 16'h0000, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd2000, 6'd1, 1'b1,
			{1'b0, 16'h0000, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_PUT, CODE_BACKSPACE, 11'd0, 6'd1, 1'b1,
			{1'b0, 16'h0000, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_PUT, 8'h41, 11'd0, 6'd1, 1'b1,
			{1'b0, 16'h0000, 11'd1, 5'd0, 7'd1}},
		'{ROW_REQUEST, REQ_PUT, 8'h7F, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_SPACE, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_FIRST_HI, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, 8'hFF, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, 8'h00, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, 8'h1F, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_BACKSPACE, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_TAB, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_RETURN, 11'd0, 6'd1, 1'b1,
			{1'b0, 16'h0000, 11'd0, 5'd0, 7'd0}},
		'{ROW_REQUEST, REQ_PUT, CODE_TAB, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_UNUSED, 8'hFF, 11'd2047, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd1, 6'd1, 1'b0, 40'd0},
		'{ROW_ATTRIBUTE, REQ_PUT, 8'hFF, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, 8'h7E, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd8, 6'd1, 1'b1,
			{1'b0, 16'hFF7E, 11'd9, 5'd0, 7'd9}},
		'{ROW_ATTRIBUTE, REQ_PUT, 8'h00, 11'd0, 6'd1, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_LINEFEED, 11'd0, 6'd24, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_LINEFEED, 11'd0, 6'd1, 1'b1,
			{1'b1, 16'h0000, 11'd1920, 5'd24, 7'd0}},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd1920, 6'd1, 1'b1,
			{1'b0, 16'h0020, 11'd1920, 5'd24, 7'd0}},
		'{ROW_REQUEST, REQ_PUT, CODE_TAB, 11'd0, 6'd9, 1'b0, 40'd0},
		'{ROW_REQUEST, REQ_PUT, CODE_TAB, 11'd0, 6'd1, 1'b1,
			{1'b1, 16'h0000, 11'd1920, 5'd24, 7'd0}},
		'{ROW_REQUEST, REQ_READ, 8'h00, 11'd0, 6'd1, 1'b0, 40'd0}
	};

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [ATTR_W-1:0] cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata   = '0;   // char_code, cell_index, zero fill
	logic [1:0]        s_tuser   = '0;   // req_type
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [39:0]       m_tdata;          // cursor_col, cursor_row,
	                                     // cursor_location, read_data, scrolled

	logic [DATA_W-1:0] shadow_cells [CELLS];
	int                shadow_col  = 0;
	int                shadow_row  = 0;
	logic [ATTR_W-1:0] shadow_attr = ATTR_RESET;

	tcw_result_t pending_reports [$];
	int          mismatch_count  = 0;
	int          quiet_cycles    = 0;
	int          sender_idle_pct = 0;
	int          receiver_idle_pct = 0;
	int          hold_requests   = 0;
	int          hold_served     = 0;
	int          hold_left       = 0;

	text_console_writer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic tcw_result_t advance_console(logic [1:0] req, logic [CHAR_W-1:0] code,
			logic [CELL_W-1:0] idx);
		tcw_result_t r;
		int          i;
		r = '0;
		case (req)
			REQ_PUT: begin
				if (code == CODE_BACKSPACE) begin
					if (shadow_col > 0)
						shadow_col--;
				end else if (code == CODE_TAB) begin
					shadow_col = (shadow_col / TAB_STOP + 1) * TAB_STOP;
				end else if (code == CODE_RETURN) begin
					shadow_col = 0;
				end else if (code == CODE_LINEFEED) begin
					shadow_col = 0;
					shadow_row++;
				end else if (code >= CODE_SPACE && code < CODE_FIRST_HI) begin
					shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
					shadow_col++;
				end
				if (shadow_col >= COLUMNS) begin
					shadow_col = 0;
					shadow_row++;
				end
				if (shadow_row >= ROWS) begin
					for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
						shadow_cells[i] = shadow_cells[i + COLUMNS];
					for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
						shadow_cells[i] = {shadow_attr, CODE_SPACE};
					shadow_row = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			REQ_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					shadow_cells[i] = {shadow_attr, CODE_SPACE};
				shadow_col = 0;
				shadow_row = 0;
			end
			REQ_READ: begin
				if (idx < CELLS)
					r.read_data = shadow_cells[idx];
			end
			default: begin
			end
		endcase
		r.cursor_col      = COL_W'(shadow_col);
		r.cursor_row      = ROW_W'(shadow_row);
		r.cursor_location = CELL_W'(shadow_row * COLUMNS + shadow_col);
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic send_request(input logic [1:0] req, input logic [CHAR_W-1:0] code,
			input logic [CELL_W-1:0] idx, input bit typed, input tcw_result_t typed_result);
		tcw_result_t predicted;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, idx, code};
		s_tuser  <= req;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = advance_console(req, code, idx);
		pending_reports.push_back(typed ? typed_result : predicted);
	endtask

	task automatic wait_for_reports;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		wait_for_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		shadow_attr = value;
		cfg_we    <= 1'b0;
	endtask

	task automatic pick_request(output logic [1:0] req, output logic [CHAR_W-1:0] code,
			output logic [CELL_W-1:0] idx);
		int unsigned roll;
		int unsigned pick;
		roll = $urandom_range(0, 999);
		code = CHAR_W'($urandom_range(0, 255));
		idx  = CELL_W'($urandom_range(0, LAST_INDEX));
		if (roll < 5) begin
			req = REQ_CLEAR;
		end else if (roll < 35) begin
			req = REQ_UNUSED;
		end else if (roll < 245) begin
			req = REQ_READ;
			if ($urandom_range(0, 99) < 85)
				idx = CELL_W'($urandom_range(0, CELLS - 1));
			else
				idx = CELL_W'($urandom_range(CELLS, LAST_INDEX));
		end else begin
			req  = REQ_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				code = CHAR_W'($urandom_range(CODE_SPACE, CODE_FIRST_HI - 1));
			else if (pick < 67)
				code = CODE_LINEFEED;
			else if (pick < 75)
				code = CODE_TAB;
			else if (pick < 81)
				code = CODE_BACKSPACE;
			else if (pick < 86)
				code = CODE_RETURN;
		end
	endtask

	// A long hold-off lets the result register fill so that the block stalls its input.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		tcw_result_t got;
		tcw_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_reports.size() == 0) begin
				$error("result beat arrived with no request waiting: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
				check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
				check_field("cursor_location", 32'(want.cursor_location),
					32'(got.cursor_location));
				check_field("read_data", 32'(want.read_data), 32'(got.read_data));
				check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [1:0]        req;
		logic [CHAR_W-1:0] code;
		logic [CELL_W-1:0] idx;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct   = SENDER_IDLE[0];
		receiver_idle_pct = RECEIVER_IDLE[0];
		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_ATTRIBUTE) begin
				write_attribute(DIRECTED_ROWS[r].code);
			end else begin
				repeat (DIRECTED_ROWS[r].reps)
					send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].code,
						DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].typed,
						DIRECTED_ROWS[r].result);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			write_attribute((phase == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
			sender_idle_pct   = SENDER_IDLE[phase];
			receiver_idle_pct = RECEIVER_IDLE[phase];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (phase == 2 && n == 40)
					hold_requests++;
				if (n == RANDOM_PER_PHASE / 2)
					wait_for_reports();
				pick_request(req, code, idx);
				send_request(req, code, idx, 1'b0, '0);
			end
		end

		wait_for_reports();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
